>>> rtl/hht_pkg.sv
// shared types and constants for the heater thermostat
`default_nettype none

package hht_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TempW = 8;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_TOGGLE = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETPOINT   = 4'd0,
    CFG_HYSTERESIS = 4'd1,
    CFG_GAIN       = 4'd2,
    CFG_OFFSET     = 4'd3
  } cfg_index_e;

  localparam logic [7:0]  SetpointReset   = 8'd180;
  localparam logic [7:0]  HysteresisReset = 8'd64;
  localparam logic [15:0] GainReset       = 16'd12252;
  localparam logic [15:0] OffsetReset     = 16'd12154;

  // one request after classification
  typedef struct packed {
    action_e              op;
    logic [SampleW-1:0]   sample;
  } item_t;

  // calibration and regulation settings
  typedef struct packed {
    logic [7:0]  setpoint;
    logic [7:0]  hysteresis;
    logic [15:0] gain;
    logic [15:0] offset;
  } cfg_t;

  // queue handshake between front and back
  typedef struct packed {
    logic  valid;
    item_t head;
  } queue_out_t;

endpackage

`default_nettype wire

>>> rtl/hht_if.sv
// channel interfaces: input requests, results and register writes
`default_nettype none

interface hht_item_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [hht_pkg::SampleW-1:0]  adc_sample;
  modport source (output valid, action, adc_sample, input ready);
  modport sink (input valid, action, adc_sample, output ready);
endinterface

interface hht_result_if;
  logic                       valid;
  logic                       ready;
  logic                       heater_on;
  logic                       running;
  logic [hht_pkg::TempW-1:0]  temperature_degrees;
  modport source (output valid, heater_on, running, temperature_degrees, input ready);
  modport sink (input valid, heater_on, running, temperature_degrees, output ready);
endinterface

interface hht_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hht_pkg::CfgIdxW-1:0]   index;
  logic [hht_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/hht_front.sv
// input stage: takes requests, classifies them and pushes them to the queue
`default_nettype none

module hht_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        in_action_i,
  input  wire logic [hht_pkg::SampleW-1:0] in_sample_i,
  output logic                             push_o,
  output hht_pkg::item_t                   push_item_o,
  input  wire logic                        queue_full_i
);

  logic           hold_q, hold_d;
  hht_pkg::item_t item_q, item_d;
  logic           take;

  assign push_o      = hold_q && !queue_full_i;
  assign push_item_o = item_q;
  assign in_ready_o  = !hold_q || !queue_full_i;
  assign take        = in_valid_i && in_ready_o;

  always_comb begin
    hold_d = hold_q;
    item_d = item_q;
    if (push_o) begin
      hold_d = 1'b0;
    end
    if (take) begin
      hold_d = 1'b1;
      unique case (hht_pkg::action_e'(in_action_i))
        hht_pkg::ACT_SAMPLE: begin
          item_d.op     = hht_pkg::ACT_SAMPLE;
          item_d.sample = in_sample_i;
        end
        hht_pkg::ACT_TOGGLE: begin
          // the sample is meaningless on a button event
          item_d.op     = hht_pkg::ACT_TOGGLE;
          item_d.sample = '0;
        end
        default: begin
          item_d.op     = hht_pkg::ACT_SAMPLE;
          item_d.sample = in_sample_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

`default_nettype wire

>>> rtl/hht_queue.sv
// two-entry queue between the front and back parts
`default_nettype none

module hht_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  hht_pkg::item_t      push_item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output hht_pkg::queue_out_t out_o
);

  hht_pkg::item_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o     = count_q[1];
  assign out_o.valid = (count_q != 2'd0);
  assign out_o.head  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hht_back.sv
// execution part: filter update, calibration, regulation and result register
`default_nettype none

module hht_back #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  hht_pkg::queue_out_t             queue_i,
  output logic                            pop_o,
  input  hht_pkg::cfg_t                   cfg_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            out_heater_o,
  output logic                            out_running_o,
  output logic [hht_pkg::TempW-1:0]       out_temp_o
);

  localparam int unsigned FiltW  = hht_pkg::SampleW + FRACTION_BITS;
  localparam int unsigned ProdW  = FiltW + 16;
  localparam int unsigned ScaleW = ProdW - 8 - FRACTION_BITS;
  localparam int unsigned TqW    = ScaleW + 1;
  // floor(2^FiltW / 3), error under one after the shift for any magnitude
  localparam logic [FiltW-1:0] Recip3 = FiltW'((64'd1 << FiltW) / 3);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_UPD  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  hht_pkg::item_t     item_q;
  logic [FiltW-1:0]   filt_q, filt_d;
  logic [FiltW-1:0]   mag_q;
  logic               neg_q;
  logic [2*FiltW-1:0] recip_prod_q;
  logic [ProdW-1:0]   cal_prod_q;
  logic               run_q, run_d;
  logic               heater_q, heater_d;
  logic               out_valid_q;
  logic               out_heater_q, out_running_q;
  logic [hht_pkg::TempW-1:0] out_temp_q;

  logic [FiltW-1:0]   target;
  logic [FiltW:0]     diff;
  logic [FiltW-1:0]   mag;
  logic [FiltW-1:0]   quot0, quot;
  logic [FiltW+1:0]   rem;
  logic [TqW-1:0]     t_q8;
  logic [TqW:0]       lo_lhs, hi_rhs;
  logic [TqW:0]       set_q8;
  logic [hht_pkg::TempW-1:0] deg;
  logic               finish;

  // divide step: magnitude of the difference times the reciprocal of three
  assign target = {item_q.sample, {FRACTION_BITS{1'b0}}};
  assign diff   = {1'b0, target} - {1'b0, filt_q};
  assign mag    = diff[FiltW] ? FiltW'(-diff) : diff[FiltW-1:0];

  // correction step: one compare and subtract brings the quotient exact
  assign quot0 = recip_prod_q[2*FiltW-1:FiltW];
  assign rem   = {2'b00, mag_q} - ({2'b00, quot0} + {1'b0, quot0, 1'b0});
  assign quot  = (rem >= (FiltW+2)'(3)) ? quot0 + FiltW'(1) : quot0;

  // calibration and thresholds
  assign t_q8   = TqW'(cal_prod_q[ProdW-1:8+FRACTION_BITS]) + TqW'(cfg_i.offset);
  assign set_q8 = (TqW+1)'({cfg_i.setpoint, 8'h00});
  assign lo_lhs = (TqW+1)'(t_q8) + (TqW+1)'(cfg_i.hysteresis);
  assign hi_rhs = set_q8 + (TqW+1)'(cfg_i.hysteresis);
  assign deg    = (|t_q8[TqW-1:16]) ? '1 : t_q8[15:8];

  assign finish = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign pop_o  = queue_i.valid && ((state_q == S_IDLE) || finish);

  always_comb begin
    state_d  = state_q;
    filt_d   = filt_q;
    run_d    = run_q;
    heater_d = heater_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (item_q.op == hht_pkg::ACT_SAMPLE) begin
          filt_d = neg_q ? filt_q - quot : filt_q + quot;
        end
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (finish) begin
          state_d = pop_o ? S_DIV : S_IDLE;
          if (item_q.op == hht_pkg::ACT_TOGGLE) begin
            run_d = !run_q;
            if (run_q) begin
              heater_d = 1'b0;
            end
          end
          if (run_d) begin
            if (lo_lhs < set_q8) begin
              heater_d = 1'b1;
            end
            if ((TqW+1)'(t_q8) > hi_rhs) begin
              heater_d = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      filt_q      <= '0;
      run_q       <= 1'b0;
      heater_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      filt_q   <= filt_d;
      run_q    <= run_d;
      heater_q <= heater_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= queue_i.head;
    end
    if (state_q == S_DIV) begin
      mag_q        <= mag;
      neg_q        <= diff[FiltW];
      recip_prod_q <= (2*FiltW)'(mag) * (2*FiltW)'(Recip3);
    end
    if (state_q == S_MUL) begin
      cal_prod_q <= ProdW'(filt_q) * ProdW'(cfg_i.gain);
    end
    if (finish) begin
      out_heater_q  <= heater_d;
      out_running_q <= run_d;
      out_temp_q    <= deg;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_heater_o  = out_heater_q;
  assign out_running_o = out_running_q;
  assign out_temp_o    = out_temp_q;

  a_stopped_heater_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> !heater_q)
    else $error("heater on while stopped");

  a_toggle_keeps_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && item_q.op == hht_pkg::ACT_TOGGLE) |=> $stable(filt_q))
    else $error("filter changed on a button event");

  a_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (rem < (FiltW+2)'(6)))
    else $error("divide-by-three correction out of range");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == S_IDLE || state_q == S_OUT))
    else $error("queue popped while an item is in flight");

  a_result_follows_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q)
    else $error("finished item not presented");

endmodule

`default_nettype wire

>>> rtl/hysteresis_heater_thermostat.sv
// top level of the hysteresis heater thermostat with iir-filtered adc input
//
//  channel  dir  handshake             payload
//  in_i     in   valid/ready           action, adc_sample
//  out_o    out  valid/ready           heater_on, running, temperature_degrees
//  cfg_i    in   valid/ready (ready=1) index, data
//
//  each request passes four steps in the back part: divide-by-three multiply,
//  quotient correction and filter write, calibration multiply, regulation
//  the four-step sequencer takes a new request only as the last one finishes
//  reset clears the filter, stops regulation, turns the heater off and loads
//  the register defaults; a stalled result holds the back part, and the
//  two-entry queue plus the input stage keep taking requests until they fill
`default_nettype none

module hysteresis_heater_thermostat #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hht_item_if.sink    in_i,
  hht_result_if.source out_o,
  hht_cfg_if.sink     cfg_i
);

  hht_pkg::cfg_t       cfg_q;
  hht_pkg::item_t      push_item;
  hht_pkg::queue_out_t queue_out;
  logic                push, queue_full, pop;

  // register writes are always taken; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint   <= hht_pkg::SetpointReset;
      cfg_q.hysteresis <= hht_pkg::HysteresisReset;
      cfg_q.gain       <= hht_pkg::GainReset;
      cfg_q.offset     <= hht_pkg::OffsetReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        hht_pkg::CFG_SETPOINT:   cfg_q.setpoint   <= cfg_i.data[7:0];
        hht_pkg::CFG_HYSTERESIS: cfg_q.hysteresis <= cfg_i.data[7:0];
        hht_pkg::CFG_GAIN:       cfg_q.gain       <= cfg_i.data;
        hht_pkg::CFG_OFFSET:     cfg_q.offset     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // front: accept and classify requests
  hht_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_action_i  (in_i.action),
    .in_sample_i  (in_i.adc_sample),
    .push_o       (push),
    .push_item_o  (push_item),
    .queue_full_i (queue_full)
  );

  // decoupling queue
  hht_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .out_o       (queue_out)
  );

  // back: filter, calibrate, regulate, hold the result
  hht_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_i       (queue_out),
    .pop_o         (pop),
    .cfg_i         (cfg_q),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_heater_o  (out_o.heater_on),
    .out_running_o (out_o.running),
    .out_temp_o    (out_o.temperature_degrees)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the hysteresis heater thermostat
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // filter precision used for both the block and the prediction
  localparam int unsigned FracBits = 8;
  localparam int unsigned FiltW    = hht_pkg::SampleW + FracBits;
  // filtered value times gain is scaled back to 1/256 degree units
  localparam int unsigned CalShift = 16 + FracBits - 8;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseRequests = 145;

  // one result as the checker sees it
  typedef struct packed {
    logic                      heater_on;
    logic                      running;
    logic [hht_pkg::TempW-1:0] temperature;
  } reading_t;

  logic clk;
  logic rst_n;

  hht_item_if   item_ch ();
  hht_result_if result_ch ();
  hht_cfg_if    cfg_ch ();

  hysteresis_heater_thermostat #(
    .FRACTION_BITS(FracBits)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (item_ch),
    .out_o (result_ch),
    .cfg_i (cfg_ch)
  );

  // requests waiting for the driver, readings waiting for the block
  hht_pkg::item_t request_backlog[$];
  reading_t       awaited_readings[$];

  // shadow copy of the thermostat: filter, run and heater flags, registers
  logic [FiltW-1:0] filt_acc   = '0;
  logic             run_state  = 1'b0;
  logic             heat_state = 1'b0;
  hht_pkg::cfg_t    shadow_cfg = '{setpoint: hht_pkg::SetpointReset,
                                   hysteresis: hht_pkg::HysteresisReset,
                                   gain: hht_pkg::GainReset,
                                   offset: hht_pkg::OffsetReset};

  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  int          errors     = 0;
  // when set, neither side idles
  bit          burst_mode = 1'b0;
  hht_pkg::item_t next_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling on the whole run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // idle length: mostly none, often short, now and then a long one
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(3, 1);
    else return $urandom_range(40, 8);
  endfunction

  // advance the shadow thermostat by one request and return what it reports
  function automatic reading_t predict_reading(hht_pkg::action_e op,
                                               logic [hht_pkg::SampleW-1:0] sample);
    longint      target;
    longint      now_val;
    longint      step_val;
    logic [63:0] temp_q8;
    logic [63:0] set_q8;
    reading_t    r;
    if (op == hht_pkg::ACT_SAMPLE) begin
      // f += (sample - f) / 3, quotient truncated toward zero
      target   = longint'(sample) * (longint'(1) << FracBits);
      now_val  = longint'(filt_acc);
      step_val = now_val + (target - now_val) / 3;
      filt_acc = step_val[FiltW-1:0];
    end else if (run_state) begin
      // stopping always drops the heater
      run_state  = 1'b0;
      heat_state = 1'b0;
    end else begin
      run_state = 1'b1;
    end
    temp_q8 = ((64'(filt_acc) * 64'(shadow_cfg.gain)) >> CalShift) + 64'(shadow_cfg.offset);
    set_q8  = 64'(shadow_cfg.setpoint) << 8;
    // regulation acts on the unsaturated temperature, also on the start request itself
    if (run_state) begin
      if (temp_q8 + 64'(shadow_cfg.hysteresis) < set_q8) heat_state = 1'b1;
      if (temp_q8 > set_q8 + 64'(shadow_cfg.hysteresis)) heat_state = 1'b0;
    end
    r.heater_on   = heat_state;
    r.running     = run_state;
    r.temperature = ((temp_q8 >> 8) > 64'd255) ? 8'd255 : temp_q8[15:8];
    return r;
  endfunction

  // request driver: takes the backlog one request at a time, with random idle gaps outside burst phases
  always @(posedge clk) begin
    if (!rst_n) begin
      item_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!item_ch.valid || item_ch.ready) begin
      // slot is empty, or the request in it is taken at this edge
      if (send_gap != 0) begin
        send_gap--;
        item_ch.valid <= 1'b0;
      end else if (request_backlog.size() != 0) begin
        next_req = request_backlog.pop_front();
        item_ch.valid      <= 1'b1;
        item_ch.action     <= next_req.op;
        item_ch.adc_sample <= next_req.sample;
        send_gap = burst_mode ? 0 : idle_span();
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // result sink: random back-pressure, none in burst phases
  always @(posedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (burst_mode) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      if ($urandom_range(2, 0) == 0) stall_left = idle_span();
    end
  end

  // monitor: check results first, then track register writes and new requests
  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      if (result_ch.valid && result_ch.ready) begin
        if (awaited_readings.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = awaited_readings.pop_front();
          if (result_ch.heater_on !== want.heater_on) begin
            $error("heater_on: expected %0b, got %0b", want.heater_on, result_ch.heater_on);
            errors++;
          end
          if (result_ch.running !== want.running) begin
            $error("running: expected %0b, got %0b", want.running, result_ch.running);
            errors++;
          end
          if (result_ch.temperature_degrees !== want.temperature) begin
            $error("temperature_degrees: expected %0d, got %0d", want.temperature,
                   result_ch.temperature_degrees);
            errors++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        // eight-bit registers keep the low byte, unknown indexes are dropped
        case (cfg_ch.index)
          hht_pkg::CFG_SETPOINT:   shadow_cfg.setpoint   = cfg_ch.data[7:0];
          hht_pkg::CFG_HYSTERESIS: shadow_cfg.hysteresis = cfg_ch.data[7:0];
          hht_pkg::CFG_GAIN:       shadow_cfg.gain       = cfg_ch.data;
          hht_pkg::CFG_OFFSET:     shadow_cfg.offset     = cfg_ch.data;
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready)
        awaited_readings.push_back(predict_reading(hht_pkg::action_e'(item_ch.action),
                                                   item_ch.adc_sample));
    end
  end

  task automatic queue_request(hht_pkg::action_e op, logic [hht_pkg::SampleW-1:0] sample);
    hht_pkg::item_t req;
    req.op     = op;
    req.sample = sample;
    request_backlog.push_back(req);
  endtask

  // hold off until the sender is empty and every reading has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (request_backlog.size() != 0 || item_ch.valid || awaited_readings.size() != 0);
  endtask

  // one register write; always drops valid before the next one is raised
  task automatic write_reg(logic [hht_pkg::CfgIdxW-1:0] idx,
                           logic [hht_pkg::CfgDataW-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // full register set; the spare high byte of the narrow registers is noise
  task automatic load_settings(logic [7:0] sp, logic [7:0] hy, logic [15:0] gn,
                               logic [15:0] of);
    write_reg(hht_pkg::CFG_SETPOINT, {8'($urandom), sp});
    write_reg(hht_pkg::CFG_HYSTERESIS, {8'($urandom), hy});
    write_reg(hht_pkg::CFG_GAIN, gn);
    write_reg(hht_pkg::CFG_OFFSET, of);
  endtask

  initial begin
    int unsigned phase;
    int unsigned issued;
    int unsigned run_len;
    int unsigned level;
    int unsigned r;
    int          s;
    logic [7:0]  sp;
    logic [7:0]  hy;
    logic [15:0] gn;
    logic [15:0] of;

    // every input known from time zero
    item_ch.valid      = 1'b0;
    item_ch.action     = hht_pkg::ACT_SAMPLE;
    item_ch.adc_sample = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = hht_pkg::CFG_SETPOINT;
    cfg_ch.data        = '0;
    result_ch.ready    = 1'b0;
    rst_n              = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: start heats at once, stopping while heating drops the heater,
    // a restart below the band heats straight away, toggles report the current temperature
    queue_request(hht_pkg::ACT_TOGGLE, 10'($urandom));
    queue_request(hht_pkg::ACT_SAMPLE, 10'd1023);
    queue_request(hht_pkg::ACT_SAMPLE, 10'd1023);
    queue_request(hht_pkg::ACT_TOGGLE, 10'($urandom));
    queue_request(hht_pkg::ACT_SAMPLE, 10'd1023);
    queue_request(hht_pkg::ACT_SAMPLE, 10'd1023);
    queue_request(hht_pkg::ACT_SAMPLE, 10'd1023);
    queue_request(hht_pkg::ACT_SAMPLE, 10'd341);
    queue_request(hht_pkg::ACT_TOGGLE, 10'($urandom));
    queue_request(hht_pkg::ACT_SAMPLE, 10'd682);
    queue_request(hht_pkg::ACT_SAMPLE, 10'd0);
    queue_request(hht_pkg::ACT_TOGGLE, 10'($urandom));
    wait_drained();

    // everything at full scale: temperature far above 255 degrees saturates
    load_settings(8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    queue_request(hht_pkg::ACT_SAMPLE, 10'd1023);
    queue_request(hht_pkg::ACT_SAMPLE, 10'd1023);
    queue_request(hht_pkg::ACT_SAMPLE, 10'd1023);
    queue_request(hht_pkg::ACT_TOGGLE, 10'($urandom));
    wait_drained();

    // setpoint below the hysteresis: lower threshold would be negative, heater stays off
    load_settings(8'd0, 8'd255, 16'd0, 16'd0);
    queue_request(hht_pkg::ACT_TOGGLE, 10'($urandom));
    queue_request(hht_pkg::ACT_TOGGLE, 10'($urandom));
    queue_request(hht_pkg::ACT_SAMPLE, 10'd0);
    wait_drained();

    // zero gain pins the temperature to the offset, so the band can be walked exactly
    load_settings(8'd150, 8'd100, 16'd0, 16'd38400);
    queue_request(hht_pkg::ACT_TOGGLE, 10'($urandom));
    queue_request(hht_pkg::ACT_TOGGLE, 10'($urandom));
    wait_drained();
    // below the band: heater on
    write_reg(hht_pkg::CFG_OFFSET, 16'd38200);
    queue_request(hht_pkg::ACT_SAMPLE, 10'($urandom));
    wait_drained();
    // inside the band: heater holds on
    write_reg(hht_pkg::CFG_OFFSET, 16'd38400);
    queue_request(hht_pkg::ACT_SAMPLE, 10'($urandom));
    wait_drained();
    // above the band: heater off, then writes to unknown indexes must change nothing
    write_reg(hht_pkg::CFG_OFFSET, 16'd38600);
    write_reg(4'(hht_pkg::CFG_OFFSET) + 4'd1, 16'hFFFF);
    write_reg(4'hF, 16'h0000);
    queue_request(hht_pkg::ACT_SAMPLE, 10'($urandom));

    // random phases: the filter is swept through runs of samples around a moving level
    for (phase = 0; phase < RandomPhases; phase++) begin
      wait_drained();
      if (phase == 0) begin
        sp = 8'd100; hy = 8'd0;   gn = 16'd0;     of = 16'd0;
      end else if (phase == RandomPhases - 1) begin
        sp = 8'd200; hy = 8'd255; gn = 16'hFFFF;  of = 16'hFFFF;
      end else if ($urandom_range(3, 0) != 0) begin
        // calibrations that mostly put the setpoint inside the reachable span
        sp = 8'($urandom_range(200, 100));
        hy = 8'($urandom_range(255, 0));
        gn = 16'($urandom_range(20000, 6000));
        of = 16'($urandom_range(16000, 0));
      end else begin
        sp = 8'($urandom_range(200, 100));
        hy = 8'($urandom_range(255, 0));
        gn = 16'($urandom);
        of = 16'($urandom);
      end
      load_settings(sp, hy, gn, of);
      if ($urandom_range(2, 0) == 0)
        write_reg(4'($urandom_range(15, 4)), 16'($urandom));
      burst_mode = (phase % 3 == 1);
      issued = 0;
      while (issued < PhaseRequests) begin
        level   = $urandom_range(1023, 0);
        run_len = $urandom_range(30, 4);
        repeat (run_len) begin
          r = $urandom_range(99, 0);
          if (r < 6) begin
            queue_request(hht_pkg::ACT_TOGGLE, 10'($urandom));
          end else if (r < 12) begin
            // stray reading anywhere in the range
            queue_request(hht_pkg::ACT_SAMPLE, 10'($urandom));
          end else begin
            s = int'(level) + int'($urandom_range(32, 0)) - 16;
            if (s < 0) s = 0;
            else if (s > 1023) s = 1023;
            queue_request(hht_pkg::ACT_SAMPLE, 10'(s));
          end
          issued++;
        end
      end
    end

    wait_drained();
    // let the clock run on to catch any stray result
    repeat (12) @(posedge clk);
    if (errors == 0 && awaited_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/hht_pkg.sv
rtl/hht_if.sv
rtl/hht_front.sv
rtl/hht_queue.sv
rtl/hht_back.sv
rtl/hysteresis_heater_thermostat.sv
tb/testbench.sv
